// File: hdl/cau_pkg.sv
// Shared types, constants and the saturation function of the complex arithmetic unit.
// No dependencies; every other file of the unit uses it.
`default_nettype none
package cau_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 8;
    localparam int PW         = 2 * DATA_WIDTH;
    localparam int SW         = PW + 1;
    localparam int XW         = PW + 2;

    localparam logic signed [XW-1:0] SAT_HI = (XW'(1) <<< (DATA_WIDTH - 1)) - XW'(1);
    localparam logic signed [XW-1:0] SAT_LO = -SAT_HI - XW'(1);

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_DIVR = 4'd3,
        OP_CDIV = 4'd4,
        OP_CONJ = 4'd5,
        OP_NORM = 4'd6,
        OP_MAG  = 4'd7,
        OP_EQ   = 4'd8,
        OP_NE   = 4'd9
    } t_op;

    typedef struct packed {
        logic [3:0]                   req_type;
        logic signed [DATA_WIDTH-1:0] a_re;
        logic signed [DATA_WIDTH-1:0] a_im;
        logic signed [DATA_WIDTH-1:0] b_re;
        logic signed [DATA_WIDTH-1:0] b_im;
    } t_req;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] res_re;
        logic signed [DATA_WIDTH-1:0] res_im;
        logic                         compare_true;
        logic                         overflow;
        logic                         divide_by_zero;
    } t_res;

    typedef struct packed {
        logic [3:0]                   op;
        logic signed [DATA_WIDTH-1:0] rr;
        logic signed [DATA_WIDTH-1:0] ri;
        logic                         cmp;
        logic                         ovf;
        logic                         dbz;
        logic                         neg_re;
        logic                         neg_im;
    } t_side;

    typedef struct packed {
        logic [PW-1:0] num_re;
        logic [PW-1:0] num_im;
        logic [PW-1:0] den;
        logic [PW-1:0] rad;
    } t_lane;

    typedef struct packed {
        logic                         ovf;
        logic signed [DATA_WIDTH-1:0] val;
    } t_sat;

    function automatic t_sat sat(input logic signed [XW-1:0] v);
        t_sat s;
        if (v > SAT_HI) begin
            s.ovf = 1'b1;
            s.val = SAT_HI[DATA_WIDTH-1:0];
        end else if (v < SAT_LO) begin
            s.ovf = 1'b1;
            s.val = SAT_LO[DATA_WIDTH-1:0];
        end else begin
            s.ovf = 1'b0;
            s.val = v[DATA_WIDTH-1:0];
        end
        return s;
    endfunction

endpackage
`default_nettype wire

// File: hdl/cau_front.sv
// Front stages: multipliers, then the sums, products results and divider operands.
// Depends on cau_pkg.
`default_nettype none
module cau_front #(
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire cau_pkg::t_req  i_req,
    output logic                o_valid,
    output cau_pkg::t_side      o_side,
    output cau_pkg::t_lane      o_lane
);
    localparam int W  = cau_pkg::DATA_WIDTH;
    localparam int PW = cau_pkg::PW;
    localparam int SW = cau_pkg::SW;
    localparam int XW = cau_pkg::XW;

    logic                 w_sq;
    logic signed [W-1:0]  w_m0b, w_m1b;
    logic signed [PW-1:0] w_p0, w_p1, w_p2, w_p3, w_p4, w_p5;
    cau_pkg::t_sat        w_sr, w_si, w_tr, w_ti;
    cau_pkg::t_side       n_s1, n_s2;
    cau_pkg::t_lane       n_lane;

    logic                 r_v1, r_v2;
    cau_pkg::t_side       r_s1, r_s2;
    cau_pkg::t_lane       r_lane;
    logic signed [PW-1:0] r_p0, r_p1, r_p2, r_p3, r_p4, r_p5;
    logic signed [W-1:0]  r_ar, r_ai, r_br;

    logic signed [SW-1:0] w_sre, w_sim, w_nb, w_are, w_aim;
    logic [W-1:0]         w_abar, w_abai, w_abbr;

    always_comb begin
        w_sq  = i_req.req_type inside {cau_pkg::OP_NORM, cau_pkg::OP_MAG};
        w_m0b = w_sq ? i_req.a_re : i_req.b_re;
        w_m1b = w_sq ? i_req.a_im : i_req.b_im;
        w_p0  = PW'(i_req.a_re) * PW'(w_m0b);
        w_p1  = PW'(i_req.a_im) * PW'(w_m1b);
        w_p2  = PW'(i_req.a_re) * PW'(i_req.b_im);
        w_p3  = PW'(i_req.a_im) * PW'(i_req.b_re);
        w_p4  = PW'(i_req.b_re) * PW'(i_req.b_re);
        w_p5  = PW'(i_req.b_im) * PW'(i_req.b_im);
        w_sr  = cau_pkg::sat(XW'(i_req.a_re) + XW'(i_req.b_re));
        w_si  = cau_pkg::sat(XW'(i_req.a_im) + XW'(i_req.b_im));
        n_s1  = '0;
        n_s1.op = i_req.req_type;
        n_s1.neg_re = i_req.a_re[W-1] ^ i_req.b_re[W-1];
        n_s1.neg_im = i_req.a_im[W-1] ^ i_req.b_re[W-1];
        case (i_req.req_type)
            cau_pkg::OP_ADD: begin
                n_s1.rr  = w_sr.val;
                n_s1.ri  = w_si.val;
                n_s1.ovf = w_sr.ovf | w_si.ovf;
            end
            cau_pkg::OP_SUB: begin
                w_sr = cau_pkg::sat(XW'(i_req.a_re) - XW'(i_req.b_re));
                w_si = cau_pkg::sat(XW'(i_req.a_im) - XW'(i_req.b_im));
                n_s1.rr  = w_sr.val;
                n_s1.ri  = w_si.val;
                n_s1.ovf = w_sr.ovf | w_si.ovf;
            end
            cau_pkg::OP_CONJ: begin
                w_si = cau_pkg::sat(-XW'(i_req.a_im));
                n_s1.rr  = i_req.a_re;
                n_s1.ri  = w_si.val;
                n_s1.ovf = w_si.ovf;
            end
            cau_pkg::OP_DIVR: n_s1.dbz = (i_req.b_re == '0);
            cau_pkg::OP_EQ:   n_s1.cmp = (i_req.a_re == i_req.b_re) && (i_req.a_im == i_req.b_im);
            cau_pkg::OP_NE:   n_s1.cmp = (i_req.a_re != i_req.b_re) || (i_req.a_im != i_req.b_im);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
        end
        r_s1 <= n_s1;
        r_p0 <= w_p0;
        r_p1 <= w_p1;
        r_p2 <= w_p2;
        r_p3 <= w_p3;
        r_p4 <= w_p4;
        r_p5 <= w_p5;
        r_ar <= i_req.a_re;
        r_ai <= i_req.a_im;
        r_br <= i_req.b_re;
    end

    always_comb begin
        w_sre  = (r_s1.op == cau_pkg::OP_MUL) ? SW'(r_p0) - SW'(r_p1) : SW'(r_p0) + SW'(r_p1);
        w_sim  = (r_s1.op == cau_pkg::OP_MUL) ? SW'(r_p2) + SW'(r_p3) : SW'(r_p3) - SW'(r_p2);
        w_nb   = SW'(r_p4) + SW'(r_p5);
        w_are  = w_sre[SW-1] ? -w_sre : w_sre;
        w_aim  = w_sim[SW-1] ? -w_sim : w_sim;
        w_abar = r_ar[W-1] ? W'(-r_ar) : W'(r_ar);
        w_abai = r_ai[W-1] ? W'(-r_ai) : W'(r_ai);
        w_abbr = r_br[W-1] ? W'(-r_br) : W'(r_br);
        w_tr   = cau_pkg::sat(XW'(w_sre >>> FRAC_BITS));
        w_ti   = cau_pkg::sat(XW'(w_sim >>> FRAC_BITS));
        n_s2   = r_s1;
        case (r_s1.op)
            cau_pkg::OP_MUL: begin
                n_s2.rr  = w_tr.val;
                n_s2.ri  = w_ti.val;
                n_s2.ovf = w_tr.ovf | w_ti.ovf;
            end
            cau_pkg::OP_NORM: begin
                n_s2.rr  = w_tr.val;
                n_s2.ovf = w_tr.ovf;
            end
            cau_pkg::OP_CDIV: begin
                n_s2.dbz    = (w_nb == '0);
                n_s2.neg_re = w_sre[SW-1];
                n_s2.neg_im = w_sim[SW-1];
            end
            default: ;
        endcase
        if (r_s1.op == cau_pkg::OP_DIVR) begin
            n_lane.num_re = PW'(w_abar);
            n_lane.num_im = PW'(w_abai);
            n_lane.den    = PW'(w_abbr);
        end else begin
            n_lane.num_re = w_are[PW-1:0];
            n_lane.num_im = w_aim[PW-1:0];
            n_lane.den    = w_nb[PW-1:0];
        end
        n_lane.rad = w_sre[PW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_s2   <= n_s2;
        r_lane <= n_lane;
    end

    assign o_valid = r_v2;
    assign o_side  = r_s2;
    assign o_lane  = r_lane;
endmodule
`default_nettype wire

// File: hdl/cau_div.sv
// Pipelined restoring divider, one quotient bit per stage, for the fractional quotients.
// Depends on cau_pkg.
`default_nettype none
module cau_div #(
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS
) (
    input  wire logic                           i_clk,
    input  wire logic [cau_pkg::PW-1:0]         i_num,
    input  wire logic [cau_pkg::PW-1:0]         i_den,
    output logic [cau_pkg::DATA_WIDTH:0]        o_quo,
    output logic                                o_ovf
);
    localparam int W  = cau_pkg::DATA_WIDTH;
    localparam int PW = cau_pkg::PW;
    localparam int DW = PW + FRAC_BITS;
    localparam int QB = W + 1;

    logic [DW-1:0] w_dvd, w_top;
    logic          w_ovf;

    logic [PW-1:0] r_rem [0:QB];
    logic [QB-1:0] r_low [0:QB];
    logic [QB-1:0] r_quo [0:QB];
    logic [PW-1:0] r_den [0:QB];
    logic          r_ovf [0:QB];

    always_comb begin
        w_dvd = DW'(i_num) << FRAC_BITS;
        w_top = w_dvd >> QB;
        w_ovf = (w_top >= DW'(i_den));
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= w_top[PW-1:0];
        r_low[0] <= w_dvd[QB-1:0];
        r_quo[0] <= '0;
        r_den[0] <= i_den;
        r_ovf[0] <= w_ovf;
    end

    for (genvar k = 1; k <= QB; k++) begin : g_stage
        logic [PW:0] w_t, w_d;
        logic        w_ge;
        always_comb begin
            w_t  = {r_rem[k-1], r_low[k-1][QB-1]};
            w_d  = w_t - {1'b0, r_den[k-1]};
            w_ge = (w_t >= {1'b0, r_den[k-1]});
        end
        always_ff @(posedge i_clk) begin
            r_rem[k] <= w_ge ? w_d[PW-1:0] : w_t[PW-1:0];
            r_low[k] <= r_low[k-1] << 1;
            r_quo[k] <= {r_quo[k-1][QB-2:0], w_ge};
            r_den[k] <= r_den[k-1];
            r_ovf[k] <= r_ovf[k-1];
        end
    end

    assign o_quo = r_quo[QB];
    assign o_ovf = r_ovf[QB];
endmodule
`default_nettype wire

// File: hdl/cau_sqrt.sv
// Pipelined integer square root, one root bit per stage, padded to the divider latency.
// Depends on cau_pkg.
`default_nettype none
module cau_sqrt (
    input  wire logic                           i_clk,
    input  wire logic [cau_pkg::PW-1:0]         i_rad,
    output logic [cau_pkg::DATA_WIDTH-1:0]      o_root
);
    localparam int W  = cau_pkg::DATA_WIDTH;
    localparam int PW = cau_pkg::PW;
    localparam int RW = W + 2;

    logic [RW-1:0] r_rem  [0:W-1];
    logic [W-1:0]  r_root [0:W-1];
    logic [PW-1:0] r_rad  [0:W-1];
    logic [W-1:0]  r_pad1, r_pad2;

    for (genvar k = 0; k < W; k++) begin : g_stage
        logic [RW-1:0] w_prem;
        logic [W-1:0]  w_proot;
        logic [PW-1:0] w_prad;
        logic [RW+1:0] w_t, w_trial, w_d;
        logic          w_ge;
        if (k == 0) begin : g_first
            assign w_prem  = '0;
            assign w_proot = '0;
            assign w_prad  = i_rad;
        end else begin : g_next
            assign w_prem  = r_rem[k-1];
            assign w_proot = r_root[k-1];
            assign w_prad  = r_rad[k-1];
        end
        always_comb begin
            w_t     = {w_prem, w_prad[PW-1:PW-2]};
            w_trial = (RW+2)'({w_proot, 2'b01});
            w_d     = w_t - w_trial;
            w_ge    = (w_t >= w_trial);
        end
        always_ff @(posedge i_clk) begin
            r_rem[k]  <= w_ge ? w_d[RW-1:0] : w_t[RW-1:0];
            r_root[k] <= {w_proot[W-2:0], w_ge};
            r_rad[k]  <= w_prad << 2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pad1 <= r_root[W-1];
        r_pad2 <= r_pad1;
    end

    assign o_root = r_pad2;
endmodule
`default_nettype wire

// File: hdl/complex_arithmetic_unit.sv
// Top level of the complex arithmetic unit: front stages, two divider lanes, square root,
// the side pipeline and the result register. Depends on cau_pkg, cau_front, cau_div, cau_sqrt.
//
//   channel   handshake            payload
//   request   start, busy          i_req (cau_pkg::t_req)
//   result    o_done               o_res (cau_pkg::t_res)
//
// One request is taken every cycle; busy stays low.
// A result passes DATA_WIDTH + 5 register stages. The divider, which retires one quotient
// bit per stage, sets the depth of the pipeline.
// Reset clears only the valid bits of the pipeline.
// Results are shown for one cycle under o_done; the receiver cannot stall.
`default_nettype none
module complex_arithmetic_unit #(
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    input  wire cau_pkg::t_req  i_req,
    output logic                busy,
    output logic                o_done,
    output cau_pkg::t_res       o_res
);
    localparam int W   = cau_pkg::DATA_WIDTH;
    localparam int XW  = cau_pkg::XW;
    localparam int LAT = W + 2;

    logic           w_fv;
    cau_pkg::t_side w_fside;
    cau_pkg::t_lane w_lane;
    logic [W:0]     w_qre, w_qim;
    logic           w_ore, w_oim;
    logic [W-1:0]   w_root;
    cau_pkg::t_side w_sd;
    cau_pkg::t_sat  w_re, w_im;
    cau_pkg::t_res  n_res;

    logic           r_vd [0:LAT-1];
    cau_pkg::t_side r_sd [0:LAT-1];
    logic           r_done;
    cau_pkg::t_res  r_res;

    function automatic cau_pkg::t_sat qsat(input logic neg, input logic [W:0] q,
                                           input logic ovf);
        cau_pkg::t_sat s;
        if (ovf) begin
            s.ovf = 1'b1;
            s.val = neg ? cau_pkg::SAT_LO[W-1:0] : cau_pkg::SAT_HI[W-1:0];
        end else begin
            s = cau_pkg::sat(neg ? -XW'(q) : XW'(q));
        end
        return s;
    endfunction

    assign busy = 1'b0;

    cau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_req   (i_req),
        .o_valid (w_fv),
        .o_side  (w_fside),
        .o_lane  (w_lane)
    );

    cau_div #(.FRAC_BITS(FRAC_BITS)) u_div_re (
        .i_clk (i_clk),
        .i_num (w_lane.num_re),
        .i_den (w_lane.den),
        .o_quo (w_qre),
        .o_ovf (w_ore)
    );

    cau_div #(.FRAC_BITS(FRAC_BITS)) u_div_im (
        .i_clk (i_clk),
        .i_num (w_lane.num_im),
        .i_den (w_lane.den),
        .o_quo (w_qim),
        .o_ovf (w_oim)
    );

    cau_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_rad  (w_lane.rad),
        .o_root (w_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_vd[k] <= 1'b0;
            end
        end else begin
            r_vd[0] <= w_fv;
            for (int k = 1; k < LAT; k++) begin
                r_vd[k] <= r_vd[k-1];
            end
        end
        r_sd[0] <= w_fside;
        for (int k = 1; k < LAT; k++) begin
            r_sd[k] <= r_sd[k-1];
        end
    end

    always_comb begin
        w_sd  = r_sd[LAT-1];
        w_re  = qsat(w_sd.neg_re && (w_qre != '0), w_qre, w_ore);
        w_im  = qsat(w_sd.neg_im && (w_qim != '0), w_qim, w_oim);
        n_res = '0;
        case (w_sd.op)
            cau_pkg::OP_DIVR, cau_pkg::OP_CDIV: begin
                if (w_sd.dbz) begin
                    n_res.divide_by_zero = 1'b1;
                end else begin
                    n_res.res_re   = w_re.val;
                    n_res.res_im   = w_im.val;
                    n_res.overflow = w_re.ovf | w_im.ovf;
                end
            end
            cau_pkg::OP_MAG: begin
                w_re = cau_pkg::sat(XW'(w_root));
                n_res.res_re   = w_re.val;
                n_res.overflow = w_re.ovf;
            end
            default: begin
                n_res.res_re       = w_sd.rr;
                n_res.res_im       = w_sd.ri;
                n_res.compare_true = w_sd.cmp;
                n_res.overflow     = w_sd.ovf;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_vd[LAT-1];
        end
        r_res <= n_res;
    end

    assign o_done = r_done;
    assign o_res  = r_res;

    a_dbz_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.divide_by_zero) |->
            (o_res.res_re == '0 && o_res.res_im == '0 && !o_res.overflow))
        else $error("Divide by zero result is not clean.");

    a_cmp_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.compare_true) |->
            (o_res.res_re == '0 && o_res.res_im == '0 && !o_res.overflow))
        else $error("Comparison result carries data.");

    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vd[LAT-1] |=> o_done)
        else $error("A valid item left the pipeline without a result strobe.");

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("Busy was raised.");
endmodule
`default_nettype wire
